FILE: hdl/mme_pkg.sv
// Shared types, widths and helpers of the matrix multiply engine.
package mme_pkg;

	localparam int ELEM_W    = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 8;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [CFG_W-1:0]         dim_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// configuration register indexes; the last one is unused
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2,
		REG_SPARE     = 2'd3
	} reg_index_t;

	// control that travels with one multiply-accumulate step
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic dim_t eff_dim(input dim_t v, input dim_t max_dim);
		dim_t r;
		r = v;
		if (v == '0) r = dim_t'(1);
		else if (v > max_dim) r = max_dim;
		return r;
	endfunction

endpackage

FILE: hdl/mme_store.sv
// Element store: one write port, one read port, registered read data.
module mme_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  mme_pkg::elem_t    wdata,
	input  logic [ADDR_W-1:0] raddr,
	output mme_pkg::elem_t    rdata
);
	import mme_pkg::*;

	elem_t mem [DEPTH];
	elem_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/mme_mac.sv
// Multiply-accumulate unit with final shift and saturation.
module mme_mac #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mme_pkg::mac_ctl_t  issue,
	input  mme_pkg::elem_t     a_data,
	input  mme_pkg::elem_t     b_data,
	input  logic               take,
	output logic               res_valid,
	output mme_pkg::elem_t     res_value
);
	import mme_pkg::*;

	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

	mac_ctl_t                  ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;
	logic signed [ACC_W-1:0]   shifted;
	logic [ACC_W-ELEM_W:0]     hi_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			if (ctl_s2.valid && ctl_s2.last) begin
				done_q <= 1'b1;
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_data) * PROD_W'(b_data);
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// floor shift, then clamp to the signed word range
	assign shifted = acc_q >>> FRAC_BITS;
	assign hi_bits = shifted[ACC_W-1:ELEM_W-1];

	always_comb begin
		if ((&hi_bits) || !(|hi_bits)) begin
			res_value = shifted[ELEM_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			res_value = {1'b1, {(ELEM_W-1){1'b0}}};
		end else begin
			res_value = {1'b0, {(ELEM_W-1){1'b1}}};
		end
	end

	assign res_valid = done_q;

endmodule

FILE: hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: load control, sequencer, output register.
//
// The engine takes matrix A (rows_a x inner_dim) and then matrix B
// (inner_dim x cols_b) as signed Q16.16 words in row-major order, one word per
// accepted input cycle, into two on-chip stores. Loading runs at one word per
// cycle. When the last B word is taken the engine stalls its input and emits
// the rows_a x cols_b product in row-major order, each word tagged with its row,
// column and a last flag on the final one. Each result is the exact dot product
// of a row of A and a column of B, shifted right by FRAC_BITS (rounding toward
// minus infinity) and saturated to 32 bits. One shared multiply-accumulate unit
// does the work: each result takes inner_dim store reads, then passes the store
// read register, the multiplier stage and the accumulator stage, and waits while
// the output is stalled; the next result starts only once it is handed over. The
// next load may start while the final result still waits in the output register.
// Register values of zero act as one and values above MAX_DIM act as MAX_DIM;
// any write to rows_a, inner_dim or cols_b restarts the load. Write registers
// only while the engine is idle.
module matrix_multiply_engine #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mme_pkg::elem_t                  element,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mme_pkg::elem_t                  product_value,
	output logic [mme_pkg::IDX_W-1:0]       result_row,
	output logic [mme_pkg::IDX_W-1:0]       result_col,
	output logic                            last
);
	import mme_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam dim_t MAX_DIM_V = dim_t'(MAX_DIM);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_MAC  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t state_q;
	dim_t   rows_a_q, inner_dim_q, cols_b_q;
	dim_t   r_n, k_n, c_n;
	cnt_t   cnt_q, a_total, total, b_off;
	idx_t   i_q, j_q, k_q;

	logic   in_accept;
	logic   left_we, right_we;
	logic   k_last, j_last, i_last;
	cnt_t   a_addr, b_addr;
	elem_t  a_data, b_data, res_value;
	logic   res_valid, take;
	mac_ctl_t issue;

	logic   out_valid_q, last_q;
	elem_t  value_q;
	idx_t   row_q, col_q;

	assign r_n = eff_dim(rows_a_q, MAX_DIM_V);
	assign k_n = eff_dim(inner_dim_q, MAX_DIM_V);
	assign c_n = eff_dim(cols_b_q, MAX_DIM_V);

	assign a_total = cnt_t'(r_n) * cnt_t'(k_n);
	assign total   = a_total + cnt_t'(k_n) * cnt_t'(c_n);
	assign b_off   = cnt_q - a_total;

	// take words only while loading
	assign in_stall  = (state_q != ST_LOAD);
	assign in_accept = in_valid && !in_stall;
	assign left_we   = in_accept && (cnt_q < a_total);
	assign right_we  = in_accept && !(cnt_q < a_total);

	assign k_last = (dim_t'(k_q) == k_n - dim_t'(1));
	assign j_last = (dim_t'(j_q) == c_n - dim_t'(1));
	assign i_last = (dim_t'(i_q) == r_n - dim_t'(1));

	// row i of A starts at i*inner_dim, column j of B steps by cols_b
	assign a_addr = cnt_t'(i_q) * cnt_t'(k_n) + cnt_t'(k_q);
	assign b_addr = cnt_t'(k_q) * cnt_t'(c_n) + cnt_t'(j_q);

	assign issue.valid = (state_q == ST_MAC);
	assign issue.first = (k_q == '0);
	assign issue.last  = k_last;

	// hand the finished result over once the output register is free
	assign take = (state_q == ST_WAIT) && res_valid && (!out_valid_q || !out_stall);

	mme_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_left (
		.clk   (clk),
		.we    (left_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (element),
		.raddr (a_addr[ADDR_W-1:0]),
		.rdata (a_data)
	);

	mme_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_right (
		.clk   (clk),
		.we    (right_we),
		.waddr (b_off[ADDR_W-1:0]),
		.wdata (element),
		.raddr (b_addr[ADDR_W-1:0]),
		.rdata (b_data)
	);

	mme_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.a_data    (a_data),
		.b_data    (b_data),
		.take      (take),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// configuration registers, load counter and result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
			cnt_q       <= '0;
			state_q     <= ST_LOAD;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_A: begin
						rows_a_q <= cfg_data;
						cnt_q    <= '0;
					end
					REG_INNER_DIM: begin
						inner_dim_q <= cfg_data;
						cnt_q       <= '0;
					end
					REG_COLS_B: begin
						cols_b_q <= cfg_data;
						cnt_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_LOAD: begin
					if (in_accept) begin
						if (cnt_q + cnt_t'(1) >= total) begin
							// B is complete: restart the count, start computing
							cnt_q   <= '0;
							state_q <= ST_MAC;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
						end else begin
							cnt_q <= cnt_q + cnt_t'(1);
						end
					end
				end
				ST_MAC: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + idx_t'(1);
					end
				end
				ST_WAIT: begin
					if (take) begin
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								i_q     <= '0;
								state_q <= ST_LOAD;
							end else begin
								i_q     <= i_q + idx_t'(1);
								state_q <= ST_MAC;
							end
						end else begin
							j_q     <= j_q + idx_t'(1);
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= res_value;
			row_q   <= i_q;
			col_q   <= j_q;
			last_q  <= i_last && j_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = value_q;
	assign result_row    = row_q;
	assign result_col    = col_q;
	assign last          = last_q;

endmodule
